### src/sha256_pkg.sv
// Shared types, constants and the rotate helper for the SHA-256 stream hasher.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic       put_byte;    // write data_byte at byte position
        logic       put_pad;     // write 0x80 mark and clear the rest of the block
        logic       clear_blk;   // zero all block words
        logic       put_len;     // write bit length into words 14 and 15
        logic       load_work;   // copy chaining hash into working vars
        logic       do_round;    // run one round
        logic       fold;        // add working vars into chaining hash
        logic       rearm;       // restore initial hash, zero the count
        logic       count_inc;   // advance the byte count
        logic [7:0] data_byte;
        logic [5:0] round;
        logic [2:0] out_sel;
    } sha_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] pos;
    } sha_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### src/sha256_dpath.sv
// Datapath: block buffer, schedule window, round unit, chaining hash, byte count.
`default_nettype none
module sha256_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::sha_cmd_t  cmd,
    output sha256_pkg::sha_stat_t      stat,
    output logic [31:0]                hash_word
);
    import sha256_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] win_reg [16];
    logic [31:0] v_reg   [8];
    logic [31:0] h_reg   [8];
    logic [60:0] count_reg;

    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [1:0]  bsel;
    logic [63:0] bits;
    logic [31:0] x2, x15, s0, s1, wt, t1, t2, ch, maj, e1, e0;
    logic [3:0]  r;

    assign pos  = count_reg[5:0];
    assign widx = pos[5:2];
    assign bsel = pos[1:0];
    assign bits = {count_reg, 3'b000};
    assign r    = cmd.round[3:0];
    assign stat.pos  = pos;
    assign hash_word = h_reg[cmd.out_sel];

    // schedule word and round sums
    always_comb
    begin
        x2  = win_reg[r - 4'd2];
        x15 = win_reg[r - 4'd15];
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        if (cmd.round < 6'd16)
            wt = blk_reg[r];
        else
            wt = s1 + win_reg[r - 4'd7] + s0 + win_reg[r];
        e1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        e0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + e1 + ch + ROUND_K[cmd.round] + wt;
        t2  = e0 + maj;
    end

    // hold byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.rearm)
            count_reg <= '0;
        else if (cmd.count_inc)
            count_reg <= count_reg + 61'd1;
    end

    // hold chaining hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_HASH[i];
        end
        else if (cmd.rearm)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_HASH[i];
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    // update block words, window and working vars
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte || cmd.put_pad)
        begin
            case (bsel)
                2'd0: blk_reg[widx] <= {cmd.data_byte, 24'd0};
                2'd1: blk_reg[widx][23:16] <= cmd.data_byte;
                2'd2: blk_reg[widx][15:8]  <= cmd.data_byte;
                default: blk_reg[widx][7:0] <= cmd.data_byte;
            endcase
            if (cmd.put_pad)
            begin
                for (int i = 0; i < 16; i++)
                    if (4'(i) > widx)
                        blk_reg[i] <= '0;
            end
        end
        if (cmd.clear_blk)
        begin
            for (int i = 0; i < 16; i++)
                blk_reg[i] <= '0;
        end
        if (cmd.put_len)
        begin
            blk_reg[14] <= bits[63:32];
            blk_reg[15] <= bits[31:0];
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        if (cmd.do_round)
        begin
            win_reg[r] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end
endmodule
`default_nettype wire

### src/sha256_ctrl.sv
// Controller: sequences byte intake, padding, compression and digest output.
`default_nettype none
module sha256_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire sha256_pkg::in_beat_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output sha256_pkg::out_beat_t       out_data,
    output sha256_pkg::sha_cmd_t        cmd,
    input  wire sha256_pkg::sha_stat_t  stat,
    input  wire logic [31:0]            hash_word
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_LEN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       last_reg, last_next;     // message ends after this compression
    logic       two_reg, two_next;       // padding spills into a second block
    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;

    // track whether padding has been written for this message
    logic done_pad, done_pad_reg;
    assign done_pad = done_pad_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data.digest_word = hash_word;
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    // decode state into datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.data_byte = in_data.msg_byte;
        cmd.round     = round_reg;
        cmd.out_sel   = idx_reg;
        state_next = state_reg;
        round_next = round_reg;
        last_next  = last_reg;
        two_next   = two_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_data.has_byte)
                begin
                    cmd.put_byte  = 1'b1;
                    cmd.count_inc = 1'b1;
                    last_next = in_data.last;
                    if (stat.pos == 6'd63)
                        state_next = S_LOAD;
                    else if (in_data.last)
                        state_next = S_PAD;
                end
                else if (in_valid && in_data.last)
                begin
                    last_next  = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.put_pad   = 1'b1;
                cmd.data_byte = 8'h80;
                two_next   = (stat.pos >= 6'd56);
                state_next = (stat.pos >= 6'd56) ? S_LOAD : S_LEN;
            end
            S_LEN:
            begin
                cmd.put_len = 1'b1;
                two_next   = 1'b0;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_work = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (two_reg)
                begin
                    cmd.clear_blk = 1'b1;
                    state_next = S_LEN;
                end
                else if (last_reg)
                begin
                    // a full block with last still needs its pad block
                    if (stat.pos == 6'd0 && !ov_reg && idx_reg == 3'd0 && !done_pad)
                        state_next = S_PAD;
                    else
                    begin
                        idx_next   = '0;
                        ov_next    = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        ov_next    = 1'b0;
                        last_next  = 1'b0;
                        cmd.rearm  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            round_reg    <= '0;
            last_reg     <= 1'b0;
            two_reg      <= 1'b0;
            idx_reg      <= '0;
            ov_reg       <= 1'b0;
            done_pad_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            last_reg  <= last_next;
            two_reg   <= two_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            if (state_reg == S_PAD)
                done_pad_reg <= 1'b1;
            else if (state_reg == S_IDLE)
                done_pad_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### src/sha256_stream_hasher.sv
// Top level of the byte-stream SHA-256 hasher.
//   channel | dir | payload    | handshake
//   in      | in  | in_beat_t  | in_valid / in_stall
//   out     | out | out_beat_t | out_valid / out_stall
// A plain byte is taken without stalling the input; a byte that fills a block
// stalls it while the single round unit does the 64 rounds, one per cycle.
// A last beat adds padding and one or two compressions, then eight digest beats.
// Reset restores the initial hash and zeroes the byte count.
// The output stall holds the digest word in place; input is stalled meanwhile.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire sha256_pkg::in_beat_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output sha256_pkg::out_beat_t       out_data
);
    import sha256_pkg::*;

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] hash_word;

    sha256_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cmd(cmd), .stat(stat), .hash_word(hash_word)
    );

    sha256_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .hash_word(hash_word)
    );

`ifndef ASSERT_OFF
    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while digest pending");
    a_round_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_round |-> !cmd.put_byte) else $error("byte write during round");
    a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_word) |=> !out_valid)
        else $error("digest did not end");
`endif
endmodule
`default_nettype wire

### bench/tb_sha256_stream_hasher.sv
// Self-checking testbench for the byte-stream SHA-256 hasher.
`default_nettype none
module tb_sha256_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b1;
    out_beat_t out_data;

    // digest words still owed by the block, oldest first
    out_beat_t digest_queue[$];
    int        mismatch_count = 0;
    int        digest_words_seen = 0;
    int        messages_sent = 0;
    int        idle_cycles = 0;
    bit        hold_receiver = 1'b0;
    bit        receiver_random = 1'b0;

    // shadow hash state
    logic [31:0] shadow_hash [8];
    logic [31:0] shadow_block [16];
    logic [60:0] shadow_count;

    sha256_stream_hasher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    // run 64 rounds over the shadow block and fold into the shadow hash
    task automatic compress_shadow();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                sched[t] = shadow_block[t];
            else
            begin
                s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
            end
        end
        for (int i = 0; i < 8; i++)
            v[i] = shadow_hash[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            shadow_hash[i] += v[i];
    endtask

    task automatic place_byte(input int pos, input logic [7:0] b);
        int sh;
        sh = (3 - (pos % 4)) * 8;
        if (pos % 4 == 0)
            shadow_block[pos / 4] = '0;
        shadow_block[pos / 4] |= 32'(b) << sh;
    endtask

    task automatic rearm_shadow();
        for (int i = 0; i < 8; i++)
            shadow_hash[i] = INIT_HASH[i];
        shadow_count = '0;
    endtask

    // advance the shadow hasher by one accepted beat
    task automatic predict_digest(input in_beat_t beat);
        int pos;
        logic [63:0] bit_len;
        out_beat_t word;
        if (beat.has_byte)
        begin
            pos = int'(shadow_count[5:0]);
            place_byte(pos, beat.msg_byte);
            shadow_count = shadow_count + 61'd1;
            if (pos == 63)
                compress_shadow();
        end
        if (beat.last)
        begin
            pos = int'(shadow_count[5:0]);
            place_byte(pos, 8'h80);
            for (int i = pos / 4 + 1; i < 16; i++)
                shadow_block[i] = '0;
            if (pos >= 56)
            begin
                compress_shadow();
                for (int i = 0; i < 16; i++)
                    shadow_block[i] = '0;
            end
            bit_len = {shadow_count, 3'b000};
            shadow_block[14] = bit_len[63:32];
            shadow_block[15] = bit_len[31:0];
            compress_shadow();
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = shadow_hash[i];
                word.word_index = 3'(i);
                word.last_word = (i == 7);
                digest_queue.push_back(word);
            end
            rearm_shadow();
            messages_sent++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // send one beat, with a random gap first; valid stays up for a following beat
    task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_data <= '{msg_byte: b, has_byte: hb, last: lst};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest('{msg_byte: b, has_byte: hb, last: lst});
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // check each digest beat against the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            digest_words_seen++;
            if (digest_queue.size() == 0)
                report_mismatch("unexpected word", out_data.digest_word, '0);
            else
            begin
                if (out_data.digest_word !== digest_queue[0].digest_word)
                    report_mismatch("digest_word", out_data.digest_word,
                                    digest_queue[0].digest_word);
                if (out_data.word_index !== digest_queue[0].word_index)
                    report_mismatch("word_index", 32'(out_data.word_index),
                                    32'(digest_queue[0].word_index));
                if (out_data.last_word !== digest_queue[0].last_word)
                    report_mismatch("last_word", 32'(out_data.last_word),
                                    32'(digest_queue[0].last_word));
                void'(digest_queue.pop_front());
            end
        end
    end

    // drive the output stall: held high for pressure, random, or held low
    always @(negedge clk)
    begin
        if (hold_receiver)
            out_stall <= 1'b1;
        else if (!receiver_random)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d words pending", digest_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        // empty message, then empty beats that do nothing
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        // byte together with last, extremes of the byte
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        // "abc"
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_block_edges();
        // longest single-block pad, padding overflow
        send_message(55);
        send_message(56);
        // byte with last fills the block, pad goes into a block of its own
        for (int i = 0; i < 63; i++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        // hold the receiver while more messages arrive
        hold_receiver = 1'b1;
        fork
            begin
                repeat (400)
                    @(negedge clk);
                hold_receiver = 1'b0;
            end
            begin
                send_message(3);
                send_message(0);
                send_message(2);
            end
        join
    endtask

    task automatic test_random_messages();
        int budget;
        int len;
        budget = 20;
        receiver_random = 1'b1;
        while (budget > 0)
        begin
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0);
                send_beat(8'($urandom), 1'b1, 1'b0);
            end
            send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            budget -= len + 1;
        end
        receiver_random = 1'b0;
    endtask

    initial
    begin
        rearm_shadow();
        for (int i = 0; i < 16; i++)
            shadow_block[i] = '0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_block_edges();
        test_backpressure();
        test_random_messages();
        in_valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        $display("hashed %0d messages, checked %0d digest words", messages_sent,
                 digest_words_seen);
        $display("covered empty, block-edge, padding-overflow and stalled messages");
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
